>>> src/kts_pkg.sv
package kts_pkg;

    // Defaults for the top-level parameters
    localparam int SEQ_LEN_DEF = 5;
    localparam int KEYS_DEF    = 3;

    // Step ROM
    localparam int ROM_LEN   = 5;
    localparam int ROM_PTR_W = 3;

    localparam logic [23:0] RGB_RED   = 24'hFF0000;
    localparam logic [23:0] RGB_GREEN = 24'h00FF00;
    localparam logic [23:0] RGB_BLUE  = 24'h0000FF;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_MS_RST = 16'd50;
    localparam logic [15:0] STEP_MS_RST     = 16'd500;
    localparam logic [14:0] NOTE_FREQ0_RST  = 15'd262;
    localparam logic [14:0] NOTE_FREQ1_RST  = 15'd294;
    localparam logic [14:0] NOTE_FREQ2_RST  = 15'd330;

    // Configuration register map, word index
    typedef enum logic [2:0] {
        REG_DEBOUNCE_MS = 3'd0,
        REG_STEP_MS     = 3'd1,
        REG_NOTE_FREQ_0 = 3'd2,
        REG_NOTE_FREQ_1 = 3'd3,
        REG_NOTE_FREQ_2 = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_MANUAL    = 2'd0,
        MODE_LED_AUTO  = 2'd1,
        MODE_FULL_AUTO = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0][14:0] note_freq;
        logic [15:0]      step_ms;
        logic [15:0]      debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0] key_buttons;
        logic       mode_button;
        logic [31:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic        seq_active;
        logic [14:0] tone_freq;
        logic        tone_on;
        logic [2:0]  servo_pressed;
        logic [23:0] key2_color;
        logic [23:0] key1_color;
        logic [23:0] key0_color;
        logic [1:0]  mode;
    } result_t;

    function automatic logic [1:0] rom_key(input logic [ROM_PTR_W-1:0] ptr);
        logic [1:0] k;
        case (ptr)
            3'd0:    k = 2'd0;
            3'd1:    k = 2'd1;
            3'd2:    k = 2'd0;
            3'd3:    k = 2'd1;
            3'd4:    k = 2'd2;
            default: k = 2'd0;
        endcase
        return k;
    endfunction

    function automatic logic [23:0] rom_color(input logic [ROM_PTR_W-1:0] ptr);
        logic [23:0] c;
        case (ptr)
            3'd0:    c = RGB_BLUE;
            3'd1:    c = RGB_GREEN;
            3'd2:    c = RGB_BLUE;
            3'd3:    c = RGB_GREEN;
            3'd4:    c = RGB_RED;
            default: c = RGB_BLUE;
        endcase
        return c;
    endfunction

endpackage

>>> src/kts_apb_regs.sv
module kts_apb_regs
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output kts_pkg::cfg_t    cfg
);

    kts_pkg::cfg_t    cfg_reg;
    kts_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = kts_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms  <= kts_pkg::DEBOUNCE_MS_RST;
            cfg_reg.step_ms      <= kts_pkg::STEP_MS_RST;
            cfg_reg.note_freq[0] <= kts_pkg::NOTE_FREQ0_RST;
            cfg_reg.note_freq[1] <= kts_pkg::NOTE_FREQ1_RST;
            cfg_reg.note_freq[2] <= kts_pkg::NOTE_FREQ2_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                kts_pkg::REG_DEBOUNCE_MS: cfg_reg.debounce_ms  <= pwdata[15:0];
                kts_pkg::REG_STEP_MS:     cfg_reg.step_ms      <= pwdata[15:0];
                kts_pkg::REG_NOTE_FREQ_0: cfg_reg.note_freq[0] <= pwdata[14:0];
                kts_pkg::REG_NOTE_FREQ_1: cfg_reg.note_freq[1] <= pwdata[14:0];
                kts_pkg::REG_NOTE_FREQ_2: cfg_reg.note_freq[2] <= pwdata[14:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            kts_pkg::REG_DEBOUNCE_MS: prdata = {16'd0, cfg_reg.debounce_ms};
            kts_pkg::REG_STEP_MS:     prdata = {16'd0, cfg_reg.step_ms};
            kts_pkg::REG_NOTE_FREQ_0: prdata = {17'd0, cfg_reg.note_freq[0]};
            kts_pkg::REG_NOTE_FREQ_1: prdata = {17'd0, cfg_reg.note_freq[1]};
            kts_pkg::REG_NOTE_FREQ_2: prdata = {17'd0, cfg_reg.note_freq[2]};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

>>> src/kts_engine.sv
module kts_engine
#(
    parameter int SEQ_LEN = kts_pkg::SEQ_LEN_DEF,
    parameter int KEYS    = kts_pkg::KEYS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  kts_pkg::sample_t  sample,
    input  kts_pkg::cfg_t     cfg,
    output kts_pkg::result_t  result
);

    localparam int IDX_W = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SEQ_LEN - 1);
    localparam logic [kts_pkg::ROM_PTR_W-1:0] PTR_LAST =
        kts_pkg::ROM_PTR_W'(kts_pkg::ROM_LEN - 1);

    kts_pkg::mode_t               mode_reg,            mode_next;
    logic                         mode_button_prev_reg, mode_button_prev_next;
    logic [31:0]                  mode_accept_time_reg, mode_accept_time_next;
    logic [2:0]                   key_held_reg,        key_held_next;
    logic [2:0][31:0]             key_accept_time_reg, key_accept_time_next;
    logic                         seq_running_reg,     seq_running_next;
    logic [IDX_W-1:0]             seq_index_reg,       seq_index_next;
    logic [kts_pkg::ROM_PTR_W-1:0] rom_ptr_reg,        rom_ptr_next;
    logic [31:0]                  step_start_time_reg, step_start_time_next;
    logic [2:0][23:0]             led_color_reg,       led_color_next;
    logic [2:0]                   servo_state_reg,     servo_state_next;
    logic                         tone_state_reg,      tone_state_next;
    logic [14:0]                  tone_freq_reg,       tone_freq_next;

    logic                         mode_fire;
    logic [2:0]                   key_elapsed_ok;
    logic [31:0]                  step_elapsed;
    logic                         found;
    logic [1:0]                   k_start, k_old, k_new;

    assign mode_fire = sample.mode_button && !mode_button_prev_reg &&
                       ((sample.now_ms - mode_accept_time_reg) >= {16'd0, cfg.debounce_ms});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            key_elapsed_ok[i] = (sample.now_ms - key_accept_time_reg[i]) >=
                                {16'd0, cfg.debounce_ms};
        end
    end

    always_comb
    begin
        mode_next             = mode_reg;
        mode_button_prev_next = sample.mode_button;
        mode_accept_time_next = mode_accept_time_reg;
        key_held_next         = key_held_reg;
        key_accept_time_next  = key_accept_time_reg;
        seq_running_next      = seq_running_reg;
        seq_index_next        = seq_index_reg;
        rom_ptr_next          = rom_ptr_reg;
        step_start_time_next  = step_start_time_reg;
        led_color_next        = led_color_reg;
        servo_state_next      = servo_state_reg;
        tone_state_next       = tone_state_reg;
        tone_freq_next        = tone_freq_reg;
        found                 = 1'b0;
        k_start               = kts_pkg::rom_key('0);
        k_old                 = kts_pkg::rom_key(rom_ptr_reg);
        k_new                 = 2'd0;
        step_elapsed          = 32'd0;

        // Mode button: cycle the mode, clear the LEDs and servos, restart the sequence outside manual mode
        if (mode_fire)
        begin
            case (mode_reg)
                kts_pkg::MODE_MANUAL:    mode_next = kts_pkg::MODE_LED_AUTO;
                kts_pkg::MODE_LED_AUTO:  mode_next = kts_pkg::MODE_FULL_AUTO;
                kts_pkg::MODE_FULL_AUTO: mode_next = kts_pkg::MODE_MANUAL;
                default:                 mode_next = kts_pkg::MODE_LED_AUTO;
            endcase
            led_color_next        = '0;
            servo_state_next      = '0;
            seq_running_next      = 1'b0;
            mode_accept_time_next = sample.now_ms;
            if (mode_next != kts_pkg::MODE_MANUAL)
            begin
                seq_running_next     = 1'b1;
                seq_index_next       = '0;
                rom_ptr_next         = '0;
                step_start_time_next = sample.now_ms;
                if (int'(k_start) < KEYS)
                begin
                    led_color_next[k_start] = kts_pkg::rom_color('0);
                    if (mode_next == kts_pkg::MODE_FULL_AUTO)
                    begin
                        servo_state_next[k_start] = 1'b1;
                    end
                end
            end
        end

        // Keys in index order; a release falls back to the lowest key held
        for (int i = 0; i < KEYS; i++)
        begin
            if (sample.key_buttons[i] && !key_held_next[i])
            begin
                if (key_elapsed_ok[i])
                begin
                    key_held_next[i]        = 1'b1;
                    key_accept_time_next[i] = sample.now_ms;
                    tone_state_next         = 1'b1;
                    tone_freq_next          = cfg.note_freq[i];
                end
            end
            else if (!sample.key_buttons[i] && key_held_next[i])
            begin
                key_held_next[i] = 1'b0;
                found            = 1'b0;
                for (int j = 0; j < KEYS; j++)
                begin
                    if (!found && key_held_next[j])
                    begin
                        tone_state_next = 1'b1;
                        tone_freq_next  = cfg.note_freq[j];
                        found           = 1'b1;
                    end
                end
                if (!found)
                begin
                    tone_state_next = 1'b0;
                end
            end
        end

        // Sequence: advance once the step time has run out, or end after the last step
        step_elapsed = sample.now_ms - step_start_time_next;
        if ((mode_next == kts_pkg::MODE_LED_AUTO || mode_next == kts_pkg::MODE_FULL_AUTO) &&
            seq_running_next && (step_elapsed >= {16'd0, cfg.step_ms}))
        begin
            k_old = kts_pkg::rom_key(rom_ptr_next);
            if (int'(k_old) < KEYS)
            begin
                led_color_next[k_old]   = '0;
                servo_state_next[k_old] = 1'b0;
            end
            if (seq_index_next == IDX_LAST)
            begin
                led_color_next   = '0;
                servo_state_next = '0;
                seq_running_next = 1'b0;
            end
            else
            begin
                seq_index_next = seq_index_next + 1'b1;
                rom_ptr_next   = (rom_ptr_next == PTR_LAST) ? '0 : rom_ptr_next + 1'b1;
                k_new          = kts_pkg::rom_key(rom_ptr_next);
                if (int'(k_new) < KEYS)
                begin
                    led_color_next[k_new] = kts_pkg::rom_color(rom_ptr_next);
                    if (mode_next == kts_pkg::MODE_FULL_AUTO)
                    begin
                        servo_state_next[k_new] = 1'b1;
                    end
                end
                step_start_time_next = sample.now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg             <= kts_pkg::MODE_MANUAL;
            mode_button_prev_reg <= 1'b0;
            mode_accept_time_reg <= '0;
            key_held_reg         <= '0;
            key_accept_time_reg  <= '0;
            seq_running_reg      <= 1'b0;
            seq_index_reg        <= '0;
            rom_ptr_reg          <= '0;
            step_start_time_reg  <= '0;
            led_color_reg        <= '0;
            servo_state_reg      <= '0;
            tone_state_reg       <= 1'b0;
            tone_freq_reg        <= '0;
        end
        else if (step_en)
        begin
            mode_reg             <= mode_next;
            mode_button_prev_reg <= mode_button_prev_next;
            mode_accept_time_reg <= mode_accept_time_next;
            key_held_reg         <= key_held_next;
            key_accept_time_reg  <= key_accept_time_next;
            seq_running_reg      <= seq_running_next;
            seq_index_reg        <= seq_index_next;
            rom_ptr_reg          <= rom_ptr_next;
            step_start_time_reg  <= step_start_time_next;
            led_color_reg        <= led_color_next;
            servo_state_reg      <= servo_state_next;
            tone_state_reg       <= tone_state_next;
            tone_freq_reg        <= tone_freq_next;
        end
    end

    always_comb
    begin
        result.mode          = mode_next;
        result.key0_color    = led_color_next[0];
        result.key1_color    = led_color_next[1];
        result.key2_color    = led_color_next[2];
        result.servo_pressed = servo_state_next;
        result.tone_on       = tone_state_next;
        result.tone_freq     = tone_freq_next;
        result.seq_active    = seq_running_next;
    end

endmodule

>>> src/key_tone_and_sequence_controller.sv
// The sample's transaction loads the input register; the engine works on it there,
// and its result is loaded into the result register and offered on m_axis.
// Throughput: one sample per clock unless m_axis_tready stalls; the state update for a
// sample is a single pass through the engine between the input and result registers.
// Reset (rst_n low, asynchronous) empties both registers, sets manual mode, silent
// tone, LEDs and servos off, and loads the configuration registers with defaults.
module key_tone_and_sequence_controller
#(
    parameter int SEQ_LEN = kts_pkg::SEQ_LEN_DEF,
    parameter int KEYS    = kts_pkg::KEYS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // now_ms[31:0], mode_button[32], key_buttons[35:33]

    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // mode[1:0], key0_color[25:2], key1_color[49:26],
                                        // key2_color[73:50], servo_pressed[76:74],
                                        // tone_on[77], tone_freq[92:78], seq_active[93]

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    kts_pkg::cfg_t    cfg;
    kts_pkg::sample_t in_data_reg;
    logic             in_valid_reg;
    kts_pkg::result_t result_next;
    kts_pkg::result_t out_data_reg;
    logic             out_valid_reg;
    logic             advance;

    // Process the held sample whenever the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    // Take a new sample when the input register is empty or its sample moves on in the same cycle
    assign s_axis_tready = !in_valid_reg || advance;

    kts_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register: hold one sample transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= kts_pkg::sample_t'(s_axis_tdata[35:0]);
        end
    end

    // Mode, key and sequence state, advanced once per processed sample
    kts_engine
    #(
        .SEQ_LEN (SEQ_LEN),
        .KEYS    (KEYS)
    )
    u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .sample  (in_data_reg),
        .cfg     (cfg),
        .result  (result_next)
    );

    // Result register: hold the result until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

endmodule

>>> sim/kts_panel_checker.sv
`timescale 1ns / 100ps

module kts_panel_checker
    import kts_pkg::*;
#(
    parameter int SEQ_LEN = SEQ_LEN_DEF,
    parameter int KEYS    = KEYS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // now_ms[31:0], mode_button[32], key_buttons[35:33]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,   // mode, key0..2 colours, servos, tone_on,
                                        // tone_freq, seq_active (lowest bit up)
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    // Register copies, as last written over APB
    logic [15:0] debounce_cfg;
    logic [15:0] step_cfg;
    logic [14:0] note_hz [3];

    // Panel state
    logic [1:0]  mode_r;
    logic        mode_btn_prev;
    logic [31:0] mode_stamp;
    logic [2:0]  keys_down;
    logic [31:0] key_stamp [3];
    logic        seq_on;
    int          seq_pos;
    logic [31:0] step_stamp;
    logic [23:0] key_colour [3];
    logic [2:0]  servo_down;
    logic        tone_live;
    logic [14:0] tone_hz;

    logic [1:0]  step_key [ROM_LEN];
    logic [23:0] step_colour [ROM_LEN];

    result_t     panel_q [$];
    int          mismatches;
    int          results_seen;

    initial
    begin
        step_key[0] = 2'd0; step_colour[0] = RGB_BLUE;
        step_key[1] = 2'd1; step_colour[1] = RGB_GREEN;
        step_key[2] = 2'd0; step_colour[2] = RGB_BLUE;
        step_key[3] = 2'd1; step_colour[3] = RGB_GREEN;
        step_key[4] = 2'd2; step_colour[4] = RGB_RED;
        mismatches   = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        mismatches++;
    endtask

    task automatic flag_field(input string fld, input logic [31:0] got,
                              input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s mismatch, got 'h%0h, want 'h%0h",
                                      fld, got, want));
    endtask

    task automatic clear_panel();
        for (int k = 0; k < 3; k++)
            key_colour[k] = '0;
        servo_down = '0;
    endtask

    // Light the key of the current step; in full auto also press its servo
    task automatic light_step(input logic [31:0] now);
        int          r;
        logic [1:0]  k;
        r = seq_pos % ROM_LEN;
        k = step_key[r];
        if (k < KEYS)
        begin
            key_colour[k] = step_colour[r];
            if (mode_r == MODE_FULL_AUTO)
                servo_down[k] = 1'b1;
        end
        step_stamp = now;
    endtask

    task automatic advance_panel(input sample_t smp, output result_t res);
        logic [31:0] now;
        logic [1:0]  next_mode;
        logic [1:0]  k;
        now = smp.now_ms;

        // Mode button: debounced rising edge only
        if (smp.mode_button && !mode_btn_prev && (now - mode_stamp) >= debounce_cfg)
        begin
            case (mode_r)
                MODE_MANUAL:    next_mode = MODE_LED_AUTO;
                MODE_LED_AUTO:  next_mode = MODE_FULL_AUTO;
                MODE_FULL_AUTO: next_mode = MODE_MANUAL;
                default:        next_mode = MODE_LED_AUTO;
            endcase
            clear_panel();
            seq_on = 1'b0;
            mode_r = next_mode;
            if (next_mode != MODE_MANUAL)
            begin
                seq_on  = 1'b1;
                seq_pos = 0;
                light_step(now);
            end
            mode_stamp = now;
        end
        mode_btn_prev = smp.mode_button;

        // Keys, lowest index first
        for (int i = 0; i < 3; i++)
        begin
            if (i < KEYS)
            begin
                if (smp.key_buttons[i] && !keys_down[i])
                begin
                    if ((now - key_stamp[i]) >= debounce_cfg)
                    begin
                        keys_down[i] = 1'b1;
                        key_stamp[i] = now;
                        tone_live    = 1'b1;
                        tone_hz      = note_hz[i];
                    end
                end
                else if (!smp.key_buttons[i] && keys_down[i])
                begin
                    // Fall back to the lowest key still held; scan downwards so it wins
                    keys_down[i] = 1'b0;
                    tone_live    = 1'b0;
                    for (int j = 2; j >= 0; j--)
                    begin
                        if (j < KEYS && keys_down[j])
                        begin
                            tone_live = 1'b1;
                            tone_hz   = note_hz[j];
                        end
                    end
                end
            end
        end

        // Sequence step timing
        if ((mode_r == MODE_LED_AUTO || mode_r == MODE_FULL_AUTO) && seq_on &&
            (now - step_stamp) >= step_cfg)
        begin
            k = step_key[seq_pos % ROM_LEN];
            if (k < KEYS)
            begin
                key_colour[k] = '0;
                servo_down[k] = 1'b0;
            end
            seq_pos++;
            if (seq_pos >= SEQ_LEN)
            begin
                clear_panel();
                seq_on = 1'b0;
            end
            else
                light_step(now);
        end

        res.mode          = mode_r;
        res.key0_color    = key_colour[0];
        res.key1_color    = key_colour[1];
        res.key2_color    = key_colour[2];
        res.servo_pressed = servo_down;
        res.tone_on       = tone_live;
        res.tone_freq     = tone_hz;
        res.seq_active    = seq_on;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            debounce_cfg  = DEBOUNCE_MS_RST;
            step_cfg      = STEP_MS_RST;
            note_hz[0]    = NOTE_FREQ0_RST;
            note_hz[1]    = NOTE_FREQ1_RST;
            note_hz[2]    = NOTE_FREQ2_RST;
            mode_r        = MODE_MANUAL;
            mode_btn_prev = 1'b0;
            mode_stamp    = '0;
            keys_down     = '0;
            for (int k = 0; k < 3; k++)
                key_stamp[k] = '0;
            seq_on        = 1'b0;
            seq_pos       = 0;
            step_stamp    = '0;
            clear_panel();
            tone_live     = 1'b0;
            tone_hz       = '0;
            panel_q.delete();
            fail_count   <= 0;
            pending      <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_DEBOUNCE_MS: debounce_cfg = pwdata[15:0];
                    REG_STEP_MS:     step_cfg     = pwdata[15:0];
                    REG_NOTE_FREQ_0: note_hz[0]   = pwdata[14:0];
                    REG_NOTE_FREQ_1: note_hz[1]   = pwdata[14:0];
                    REG_NOTE_FREQ_2: note_hz[2]   = pwdata[14:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(result_t)-1:0];
                if (panel_q.size() == 0)
                begin
                    report_mismatch("no sample waiting");
                end
                else
                begin
                    want = panel_q.pop_front();
                    flag_field("mode", got.mode, want.mode);
                    flag_field("key0_color", got.key0_color, want.key0_color);
                    flag_field("key1_color", got.key1_color, want.key1_color);
                    flag_field("key2_color", got.key2_color, want.key2_color);
                    flag_field("servo_pressed", got.servo_pressed, want.servo_pressed);
                    flag_field("tone_on", got.tone_on, want.tone_on);
                    flag_field("tone_freq", got.tone_freq, want.tone_freq);
                    flag_field("seq_active", got.seq_active, want.seq_active);
                end
                results_seen++;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_panel(s_axis_tdata[$bits(sample_t)-1:0], want);
                panel_q.push_back(want);
            end

            fail_count <= mismatches;
            pending    <= panel_q.size();
        end
    end

endmodule

>>> sim/key_tone_and_sequence_controller_tb.sv
`timescale 1ns / 100ps

module key_tone_and_sequence_controller_tb;

    import kts_pkg::*;

    // Roughly 1000 samples; keep the limit well clear of what they take
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 125;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // now_ms[31:0], mode_button[32], key_buttons[35:33]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;    // mode[1:0], key0_color[25:2], key1_color[49:26],
                                  // key2_color[73:50], servo_pressed[76:74],
                                  // tone_on[77], tone_freq[92:78], seq_active[93]

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;

    // When set, neither side idles: the long back-to-back stretch
    logic        steady = 1'b0;

    // Current stamp and button levels that the random part walks through
    logic [31:0] stamp;
    logic        mode_level;
    logic [2:0]  key_levels;
    int          stamp_span;

    key_tone_and_sequence_controller dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    kts_panel_checker chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: stall at random with a chance of about 30 percent, never while steady
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 30);

    // Watchdog: give up if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one sample and hold it until the transaction completes.
    // tvalid is left high afterwards so back-to-back samples need no toggle.
    task automatic send_sample(input logic [31:0] ts, input logic mb, input logic [2:0] kb);
        if (!steady && $urandom_range(99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, kb, mb, ts};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop tvalid and hold off until every outstanding result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the end of the access cycle
    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly plausible button activity with time moving forward; a share of noise
    // with arbitrary stamps that make elapsed times wrap
    task automatic random_samples(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_sample($urandom, 1'($urandom_range(1)), 3'($urandom_range(7)));
            else
            begin
                if (pick < 11)
                    stamp = stamp + $urandom;
                else
                    stamp = stamp + $urandom_range(0, stamp_span);
                if ($urandom_range(9) == 0)
                    mode_level = ~mode_level;
                for (int k = 0; k < 3; k++)
                    if ($urandom_range(5) == 0)
                        key_levels[k] = ~key_levels[k];
                send_sample(stamp, mode_level, key_levels);
            end
        end
    endtask

    initial
    begin
        logic [15:0] debounce_pick;
        logic [15:0] step_pick;
        logic [14:0] hz [3];

        rst_n         = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        mode_level    = 1'b0;
        key_levels    = '0;
        stamp         = '0;
        stamp_span    = 100;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings (debounce 50, step 500)
        send_sample(32'd0, 1'b0, 3'b000);
        send_sample(32'd10, 1'b1, 3'b000);     // edge inside debounce: lost
        send_sample(32'd80, 1'b1, 3'b000);     // button still held: no edge
        send_sample(32'd90, 1'b0, 3'b000);
        send_sample(32'd100, 1'b1, 3'b001);    // enter LED auto, key 0 tone
        send_sample(32'd120, 1'b0, 3'b011);    // key 1 takes the tone
        send_sample(32'd130, 1'b0, 3'b010);    // key 0 released, key 1 still held
        send_sample(32'd140, 1'b0, 3'b110);    // key 2 press
        send_sample(32'd150, 1'b0, 3'b000);    // fall back to key 2, then silence
        send_sample(32'd700, 1'b0, 3'b111);    // next step, all keys pressed
        send_sample(32'd1300, 1'b1, 3'b000);   // full auto: servos follow the steps
        send_sample(32'd1800, 1'b0, 3'b100);
        send_sample(32'd2300, 1'b0, 3'b000);
        send_sample(32'd2800, 1'b0, 3'b000);
        send_sample(32'd3300, 1'b0, 3'b000);   // last step lit: the sequence ends on the next sample
        send_sample(32'hFFFF_FFF0, 1'b0, 3'b000);
        send_sample(32'hFFFF_FFFF, 1'b1, 3'b111);  // back to manual near the wrap
        send_sample(32'h0000_0020, 1'b0, 3'b000);
        send_sample(32'h0000_0030, 1'b0, 3'b001);  // within debounce across the wrap

        // Zero debounce and zero step time: every edge counts, steps end at once
        drain_results();
        apb_write(REG_DEBOUNCE_MS, 32'd0);
        apb_write(REG_STEP_MS, 32'd0);
        send_sample(32'h0000_0031, 1'b1, 3'b001);
        send_sample(32'h0000_0031, 1'b0, 3'b000);
        send_sample(32'h0000_0031, 1'b1, 3'b001);
        send_sample(32'h0000_0032, 1'b0, 3'b011);
        send_sample(32'h0000_0032, 1'b0, 3'b000);
        stamp = 32'h0000_0040;

        // Random part: several register settings, extremes among them
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0:       begin debounce_pick = 16'd50;    step_pick = 16'd500;   end
                1:       begin debounce_pick = 16'd0;     step_pick = 16'd0;     end
                2:       begin debounce_pick = 16'hFFFF;  step_pick = 16'hFFFF;  end
                3:       begin debounce_pick = 16'd0;     step_pick = 16'hFFFF;  end
                4:       begin debounce_pick = 16'hFFFF;  step_pick = 16'd0;     end
                default:
                begin
                    debounce_pick = 16'($urandom_range(0, 300));
                    step_pick     = 16'($urandom_range(1, 2000));
                end
            endcase
            for (int k = 0; k < 3; k++)
                hz[k] = 15'($urandom_range(0, 20000));
            if (p == 2)
            begin
                hz[0] = 15'd20000;
                hz[1] = 15'd0;
                hz[2] = 15'd20000;
            end
            apb_write(REG_DEBOUNCE_MS, {16'd0, debounce_pick});
            apb_write(REG_STEP_MS, {16'd0, step_pick});
            apb_write(REG_NOTE_FREQ_0, {17'd0, hz[0]});
            apb_write(REG_NOTE_FREQ_1, {17'd0, hz[1]});
            apb_write(REG_NOTE_FREQ_2, {17'd0, hz[2]});

            // Scale time steps so steps and debounce windows both get crossed
            stamp_span = ((debounce_pick > step_pick) ? debounce_pick : step_pick) / 4 + 10;
            if (p == 5)
                stamp = 32'hFFFF_F000;
            steady = (p == 3);
            random_samples(PHASE_ITEMS);
        end

        steady = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
src/kts_pkg.sv
src/kts_apb_regs.sv
src/kts_engine.sv
src/key_tone_and_sequence_controller.sv
sim/kts_panel_checker.sv
sim/key_tone_and_sequence_controller_tb.sv
